@@ design/hcbp_pkg.sv @@
package hcbp_pkg;

	// Table geometry and field widths
	localparam int SYMBOL_COUNT = 128;
	localparam int MAX_CODE_LEN = 32;
	localparam int BYTE_BITS    = 8;
	localparam int STORE_W      = 32;
	localparam int SYM_W        = 7;
	localparam int LEN_W        = 6;
	localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
	localparam int LEN_LIMIT    = (MAX_CODE_LEN < STORE_W) ? MAX_CODE_LEN : STORE_W;

	// Bit accumulator: up to 7 waiting bits plus one full code, left aligned
	localparam int ACC_W  = BYTE_BITS + STORE_W;
	localparam int DATA_W = STORE_W;
	localparam int CNT_W  = 3;

	// Operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_PAD  = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;

	// What the emit stage is sending
	typedef enum logic [1:0] {
		MODE_ENC,
		MODE_FIN,
		MODE_ACK
	} emit_mode_t;

	// Table access, issued when an item is taken
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [ADDR_W-1:0]  addr;
		logic [LEN_W-1:0]   len;
		logic [STORE_W-1:0] code;
	} mem_req_t;

	// Registered table read
	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [STORE_W-1:0] code;
	} mem_rd_t;

	// Decoded item handed to the packer
	typedef struct packed {
		logic [1:0] op;
		logic       sym_ok;
		logic       bad;
	} item_dec_t;

endpackage

@@ design/hcbp_if.sv @@
interface hcbp_item_if
	import hcbp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [SYM_W-1:0]   symbol;
	logic [STORE_W-1:0] code_value;
	logic [LEN_W-1:0]   code_length;

	modport source(output valid, operation, symbol, code_value, code_length, input ready);
	modport sink(input valid, operation, symbol, code_value, code_length, output ready);
endinterface

interface hcbp_result_if
	import hcbp_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic       load_error;
	logic       last;

	modport source(output valid, out_byte, byte_kind, load_error, last, input ready);
	modport sink(input valid, out_byte, byte_kind, load_error, last, output ready);
endinterface

@@ design/hcbp_code_mem.sv @@
module hcbp_code_mem
	import hcbp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rd_t  rd
);

	logic [LEN_W+STORE_W-1:0] code_mem_q [SYMBOL_COUNT];
	logic [LEN_W+STORE_W-1:0] rd_data_q;
	logic [SYMBOL_COUNT-1:0]  vld_q;
	logic                     rd_vld_q;

	// Table array: one write or one read per cycle, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			code_mem_q[req.addr] <= {req.len, req.code};
		end
		if (req.rd_en) begin
			rd_data_q <= code_mem_q[req.addr];
		end
	end

	// Per-entry valid bits: an unwritten entry reads as length zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rd.len  = rd_vld_q ? rd_data_q[LEN_W+STORE_W-1:STORE_W] : '0;
	assign rd.code = rd_data_q[STORE_W-1:0];

endmodule

@@ design/hcbp_packer.sv @@
module hcbp_packer
	import hcbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_dec_t dec,
	input  mem_rd_t   rd,
	output logic      ready,
	hcbp_result_if.source result
);

	// Stage 1: table data arrives
	logic       valid_s1;
	item_dec_t  dec_s1;

	// Accumulator state
	logic [BYTE_BITS-2:0] pbits_q;
	logic [CNT_W-1:0]     pcnt_q;

	// Stage 2: bytes waiting to go out
	logic               valid_s2;
	logic [DATA_W-1:0]  data_s2;
	logic [CNT_W-1:0]   cnt_s2;
	emit_mode_t         mode_s2;
	logic               err_s2;

	// Output register
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic [1:0]         out_kind_q;
	logic               out_err_q;
	logic               out_last_q;

	logic                 has_code;
	logic [ACC_W-1:0]     acc;
	logic [ACC_W-1:0]     aligned;
	logic [LEN_W-1:0]     total;
	logic [LEN_W-1:0]     shamt;
	logic [CNT_W-1:0]     nbytes;
	logic [2:0]           rem;
	logic [BYTE_BITS-2:0] new_pbits;
	logic [3:0]           pad;
	logic [7:0]           fin_byte;
	logic                 gen;
	logic                 out_free;
	logic                 emit;
	logic                 s2_free;
	logic                 s1_adv;

	// Append the code to the waiting bits and left-align the full bytes
	always_comb begin
		has_code  = (dec_s1.op == OP_ENCODE) && dec_s1.sym_ok && (rd.len != '0);
		acc       = (ACC_W'(pbits_q) << rd.len) | ACC_W'(rd.code);
		total     = LEN_W'(pcnt_q) + rd.len;
		shamt     = LEN_W'(ACC_W) - total;
		aligned   = acc << shamt;
		nbytes    = total[LEN_W-1:3];
		rem       = total[2:0];
		new_pbits = acc[BYTE_BITS-2:0] & (BYTE_BITS-1)'((8'd1 << rem) - 8'd1);
		pad       = 4'(BYTE_BITS) - 4'(pcnt_q);
		fin_byte  = 8'(15'(pbits_q) << pad);
		gen       = (dec_s1.op == OP_LOAD) || (dec_s1.op == OP_FINISH) ||
		            (has_code && (nbytes != '0));
	end

	// Handshake between stages
	assign out_free = !out_valid_q || result.ready;
	assign emit     = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || (emit && (cnt_s2 == CNT_W'(1)));
	assign s1_adv   = valid_s1 && (!gen || s2_free);
	assign ready    = !valid_s1 || s1_adv;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (push) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dec_s1 <= dec;
		end
	end

	// Waiting bits move on when the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (s1_adv) begin
			if (dec_s1.op == OP_FINISH) begin
				pbits_q <= '0;
				pcnt_q  <= '0;
			end else if (has_code) begin
				pbits_q <= new_pbits;
				pcnt_q  <= rem;
			end
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && gen) begin
			valid_s2 <= 1'b1;
		end else if (emit && (cnt_s2 == CNT_W'(1))) begin
			valid_s2 <= 1'b0;
		end
	end

	// Stage 2 payload: load from stage 1, else shift out one byte per word sent
	always_ff @(posedge clk) begin
		if (s1_adv && gen) begin
			err_s2 <= dec_s1.bad;
			case (dec_s1.op)
				OP_LOAD: begin
					data_s2 <= '0;
					cnt_s2  <= CNT_W'(1);
					mode_s2 <= MODE_ACK;
				end
				OP_FINISH: begin
					data_s2 <= {fin_byte, 4'd0, pad, (DATA_W-16)'(0)};
					cnt_s2  <= CNT_W'(2);
					mode_s2 <= MODE_FIN;
				end
				default: begin
					data_s2 <= aligned[ACC_W-1 -: DATA_W];
					cnt_s2  <= nbytes;
					mode_s2 <= MODE_ENC;
				end
			endcase
		end else if (emit) begin
			data_s2 <= data_s2 << BYTE_BITS;
			cnt_s2  <= cnt_s2 - CNT_W'(1);
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= data_s2[DATA_W-1 -: 8];
			out_err_q  <= (mode_s2 == MODE_ACK) && err_s2;
			out_last_q <= (cnt_s2 == CNT_W'(1));
			case (mode_s2)
				MODE_ACK: out_kind_q <= KIND_ACK;
				MODE_FIN: out_kind_q <= (cnt_s2 == CNT_W'(1)) ? KIND_PAD : KIND_DATA;
				default:  out_kind_q <= KIND_DATA;
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.byte_kind  = out_kind_q;
	assign result.load_error = out_err_q;
	assign result.last       = out_last_q;

endmodule

@@ design/huffman_code_bit_packer_core.sv @@
// Huffman code bit packer.
// Channel item (valid/ready): one word per operation. Load writes one code table
// entry and returns one acknowledge word with load_error set when the symbol or
// the length is out of range. Encode looks up the symbol and appends its code,
// first bit first, to the bit accumulator, returning 0 to 4 data bytes. Finish
// pads the waiting bits with zeros and returns that byte, then the pad count.
// Channel result (valid/ready): one byte per word; last marks the final word of
// an item. An item that returns nothing (operation 3, unknown or empty code)
// still passes through the pipe.
// Pipe: an item's table data is packed into the emit stage, and its first byte
// then moves into the output register, from which the word is offered.
// Throughput: one result word per cycle while result is ready; an item that
// returns words leaves the packing stage only once the emit stage has sent the
// last byte of the item before it, set by the single-byte output port.
// Reset clears the accumulator, the pipe and all table valid bits at once (no
// clearing pass); every entry then reads as length zero.
// When result stalls, the output register, the emit stage and the packing stage
// hold in turn, and item.ready falls once all three are full.
module huffman_code_bit_packer_core
	import hcbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hcbp_item_if.sink     item,
	hcbp_result_if.source result
);

	logic      accept;
	logic      pk_ready;
	logic      sym_ok;
	logic      len_ok;
	logic      bad;
	mem_req_t  req;
	mem_rd_t   rd;
	item_dec_t dec;

	// Range checks on the incoming word
	assign accept = item.valid && item.ready;
	assign sym_ok = (9'(item.symbol) < 9'(SYMBOL_COUNT));
	assign len_ok = (7'(item.code_length) <= 7'(LEN_LIMIT));
	assign bad    = !sym_ok || !len_ok;

	// Table access: loads write, encodes read
	always_comb begin
		req.rd_en = accept && (item.operation == OP_ENCODE);
		req.wr_en = accept && (item.operation == OP_LOAD) && !bad;
		req.addr  = ADDR_W'(item.symbol);
		req.len   = item.code_length;
		req.code  = item.code_value &
		            STORE_W'((33'd1 << item.code_length) - 33'd1);
	end

	assign dec.op     = item.operation;
	assign dec.sym_ok = sym_ok;
	assign dec.bad    = bad;

	assign item.ready = pk_ready;

	hcbp_code_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd     (rd)
	);

	hcbp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.dec    (dec),
		.rd     (rd),
		.ready  (pk_ready),
		.result (result)
	);

endmodule

@@ bench/tb.sv @@
module tb;
	import hcbp_pkg::*;

	// Operation code the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Cycles of result hold-off applied once, mid-run, to back up the pipe
	localparam int LONG_HOLD = 200;

	typedef struct {
		logic [1:0]         op;
		logic [SYM_W-1:0]   sym;
		logic [STORE_W-1:0] val;
		logic [LEN_W-1:0]   len;
		bit                 drain;   // hold this word until every byte is back
	} in_word_t;

	typedef struct {
		logic [7:0] data;
		logic [1:0] kind;
		logic       err;
		logic       last;
	} out_word_t;

	logic clk;
	logic arst_n;

	hcbp_item_if   item_bus();
	hcbp_result_if result_bus();

	huffman_code_bit_packer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	// Packer state as the block should hold it
	logic [STORE_W-1:0] model_code [SYMBOL_COUNT];
	logic [LEN_W-1:0]   model_len  [SYMBOL_COUNT];
	logic [6:0]         model_bits;
	int                 model_cnt;

	// Byte stream still owed by the block, oldest first
	out_word_t expected_bytes[$];

	// Words waiting to be offered, and the generator's view of the table
	in_word_t word_queue[$];
	int       planned_len[SYMBOL_COUNT];
	int       coded_syms[$];
	int       words_queued;
	int       words_counted;

	int  words_taken;
	int  bytes_checked;
	int  mismatches;
	int  n_loads, n_refused, n_encodes, n_flushes;
	int  cycle_no;
	int  send_gap;
	int  stall_left;
	bit  long_hold_done;
	in_word_t  on_wire;
	out_word_t want;

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) cycle_no <= cycle_no + 1;

	// No random gaps or stalls while bits 8:7 of the cycle count are both zero
	function automatic bit quiet_phase();
		return cycle_no[8:7] == 2'b00;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// Advance the packer state by one accepted word, queueing the bytes it owes
	task automatic pack_model(input in_word_t w);
		logic [63:0] acc;
		logic [63:0] mask;
		int          clen;
		int          total;
		int          pad;
		bit          bad;
		out_word_t   o;
		case (w.op)
			OP_LOAD: begin
				n_loads++;
				bad = (w.sym >= SYMBOL_COUNT) || (w.len > LEN_LIMIT);
				if (!bad) begin
					mask = (64'd1 << w.len) - 64'd1;
					model_code[w.sym] = w.val & mask[STORE_W-1:0];
					model_len[w.sym]  = w.len;
				end else begin
					n_refused++;
				end
				o.data = 8'd0;
				o.kind = KIND_ACK;
				o.err  = bad;
				o.last = 1'b1;
				expected_bytes.insert(expected_bytes.size(), o);
			end
			OP_ENCODE: begin
				n_encodes++;
				clen = (w.sym < SYMBOL_COUNT) ? int'(model_len[w.sym]) : 0;
				if (clen != 0) begin
					acc   = (64'(model_bits) << clen) | 64'(model_code[w.sym]);
					total = model_cnt + clen;
					while (total >= BYTE_BITS) begin
						total -= BYTE_BITS;
						o.data = acc[total +: 8];
						o.kind = KIND_DATA;
						o.err  = 1'b0;
						o.last = (total < BYTE_BITS);
						expected_bytes.insert(expected_bytes.size(), o);
					end
					model_bits = acc[6:0] & ((7'h1 << total) - 7'h1);
					model_cnt  = total;
				end
			end
			OP_FINISH: begin
				n_flushes++;
				pad    = BYTE_BITS - model_cnt;
				o.data = 8'({1'b0, model_bits} << pad);
				o.kind = KIND_DATA;
				o.err  = 1'b0;
				o.last = 1'b0;
				expected_bytes.insert(expected_bytes.size(), o);
				o.data = 8'(pad);
				o.kind = KIND_PAD;
				o.last = 1'b1;
				expected_bytes.insert(expected_bytes.size(), o);
				model_bits = '0;
				model_cnt  = 0;
			end
			default: ;
		endcase
	endtask

	// Queue one word; track which symbols the table should hold a code for
	task automatic queue_word(input logic [1:0] op, input int sym, input logic [31:0] val,
			input int len, input bit drain = 1'b0);
		in_word_t w;
		w.op    = op;
		w.sym   = sym[SYM_W-1:0];
		w.val   = val;
		w.len   = len[LEN_W-1:0];
		w.drain = drain;
		word_queue.insert(word_queue.size(), w);
		words_queued++;
		if (op == OP_LOAD && len <= LEN_LIMIT) begin
			planned_len[sym] = len;
			if (len != 0)
				coded_syms.insert(coded_syms.size(), sym);
		end
		if (op != OP_UNUSED && (op != OP_ENCODE || planned_len[sym] != 0))
			words_counted++;
	endtask

	// Random load length: mostly short codes, some long, a few empty or too long
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		else if (r < 11)
			return $urandom_range(LEN_LIMIT + 1, (1 << LEN_W) - 1);
		else if (r < 26)
			return $urandom_range(13, LEN_LIMIT);
		else
			return $urandom_range(1, 12);
	endfunction

	task automatic build_stimulus();
		int n_ld, n_enc, r, s;
		// Directed: empty flush, unknown symbol, ignored op, length extremes,
		// refused loads leaving the entry alone, multi-byte encodes and flushes with seven and eight pad bits
		queue_word(OP_FINISH, 0, 32'h0, 0);
		queue_word(OP_ENCODE, 5, 32'h0, 0);
		queue_word(OP_UNUSED, 127, 32'hFFFF_FFFF, 63);
		queue_word(OP_LOAD, 0, 32'hFFFF_FFFF, 32);
		queue_word(OP_LOAD, 127, 32'hFFFF_FFFF, 1);
		queue_word(OP_LOAD, 1, 32'h0, 33);
		queue_word(OP_LOAD, 2, 32'hFFFF_FFFF, 63);
		queue_word(OP_LOAD, 3, 32'h1234_5678, 0);
		queue_word(OP_ENCODE, 3, 32'h0, 0);
		queue_word(OP_ENCODE, 127, 32'h0, 0);
		queue_word(OP_ENCODE, 0, 32'h0, 0);
		queue_word(OP_LOAD, 4, 32'hFFFF_FF55, 7);
		queue_word(OP_ENCODE, 4, 32'h0, 0);
		queue_word(OP_LOAD, 127, 32'h0, 40);
		queue_word(OP_ENCODE, 127, 32'h0, 0);
		queue_word(OP_FINISH, 0, 32'h0, 0);
		queue_word(OP_ENCODE, 4, 32'h0, 0);
		queue_word(OP_ENCODE, 0, 32'h0, 0);
		queue_word(OP_FINISH, 0, 32'h0, 0);
		queue_word(OP_LOAD, 64, 32'h0, 32);
		queue_word(OP_ENCODE, 64, 32'h0, 0);
		queue_word(OP_LOAD, 0, 32'hA5C3_0F96, 32);
		queue_word(OP_ENCODE, 0, 32'h0, 0);
		queue_word(OP_ENCODE, 0, 32'h0, 0);
		queue_word(OP_FINISH, 0, 32'h0, 0);

		// Random: load a small alphabet, encode a message with it, mostly then flush
		while (words_counted < 360) begin
			n_ld = $urandom_range(2, 8);
			for (int i = 0; i < n_ld; i++)
				queue_word(OP_LOAD, $urandom_range(0, SYMBOL_COUNT - 1), $urandom, pick_len(),
					(i == 0) && (words_queued == 25 || $urandom_range(0, 9) == 0));
			n_enc = $urandom_range(4, 30);
			for (int i = 0; i < n_enc; i++) begin
				r = $urandom_range(0, 99);
				if (r < 85 && coded_syms.size() != 0) begin
					s = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
					queue_word(OP_ENCODE, s, $urandom, $urandom_range(0, 63));
				end else if (r < 92)
					queue_word(OP_ENCODE, $urandom_range(0, SYMBOL_COUNT - 1), $urandom,
						$urandom_range(0, 63));
				else if (r < 96)
					queue_word(OP_UNUSED, $urandom_range(0, SYMBOL_COUNT - 1), $urandom,
						$urandom_range(0, 63));
				else
					queue_word(OP_LOAD, $urandom_range(0, SYMBOL_COUNT - 1), $urandom,
						pick_len());
			end
			if ($urandom_range(0, 99) < 85)
				queue_word(OP_FINISH, $urandom_range(0, SYMBOL_COUNT - 1), $urandom,
					$urandom_range(0, 63));
		end
	endtask

	// Item driver: keeps valid up across back-to-back words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid       <= 1'b0;
			item_bus.operation   <= OP_LOAD;
			item_bus.symbol      <= '0;
			item_bus.code_value  <= '0;
			item_bus.code_length <= '0;
			send_gap = 0;
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				pack_model(on_wire);
				words_taken++;
				send_gap = quiet_phase() ? 0 : gap_len();
			end
			if (!item_bus.valid || item_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_bus.valid <= 1'b0;
				end else if (word_queue.size() != 0 &&
						!(word_queue[0].drain && expected_bytes.size() != 0)) begin
					on_wire = word_queue.pop_front();
					item_bus.valid       <= 1'b1;
					item_bus.operation   <= on_wire.op;
					item_bus.symbol      <= on_wire.sym;
					item_bus.code_value  <= on_wire.val;
					item_bus.code_length <= on_wire.len;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result ready: random stalls, plus one long hold-off while words keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_left == 0 && !long_hold_done && words_taken >= 150) begin
				stall_left     = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (stall_left == 0 && !quiet_phase() && $urandom_range(0, 3) == 0) begin
				stall_left = gap_len();
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word: byte=%02h kind=%0d err=%0d last=%0d", $time,
					result_bus.out_byte, result_bus.byte_kind, result_bus.load_error,
					result_bus.last);
			end else begin
				want = expected_bytes.pop_front();
				if (result_bus.out_byte !== want.data) begin
					mismatches++;
					$display("%0t: out_byte expected %02h, got %02h", $time, want.data,
						result_bus.out_byte);
				end
				if (result_bus.byte_kind !== want.kind) begin
					mismatches++;
					$display("%0t: byte_kind expected %0d, got %0d", $time, want.kind,
						result_bus.byte_kind);
				end
				if (result_bus.load_error !== want.err) begin
					mismatches++;
					$display("%0t: load_error expected %0d, got %0d", $time, want.err,
						result_bus.load_error);
				end
				if (result_bus.last !== want.last) begin
					mismatches++;
					$display("%0t: last expected %0d, got %0d", $time, want.last,
						result_bus.last);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Reset, stimulus, end of run
	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < SYMBOL_COUNT; i++) begin
			model_code[i]  = '0;
			model_len[i]   = '0;
			planned_len[i] = 0;
		end
		model_bits = '0;
		model_cnt  = 0;
		build_stimulus();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (words_taken != words_queued || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d table loads (%0d refused), %0d encodes, %0d flushes;",
			n_loads, n_refused, n_encodes, n_flushes);
		$display("%0d result words checked, with a %0d-cycle output hold-off mid-run.",
			bytes_checked, LONG_HOLD);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
design/hcbp_pkg.sv
design/hcbp_if.sv
design/hcbp_code_mem.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer_core.sv
bench/tb.sv
